[design/mbtm_pkg.sv]
// ----------------------------------------------------------------------------
// mbtm_pkg: shared types and constants of the token meter
// Field widths, request and register codes, datapath command and status.
// ----------------------------------------------------------------------------
package mbtm_pkg;

    localparam int MAX_BUCKETS     = 4;
    localparam int DEFAULT_BUCKETS = 4;

    localparam int REQ_W      = 2;
    localparam int SRC_W      = 3;
    localparam int CAP_W      = 16;
    localparam int WIN_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TAKE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESET = 2'd2;

    // register map
    localparam int CFG_CAP_BASE = 0;
    localparam int CFG_WIN_BASE = 4;

    // divider: 33-bit dividend padded to an even width, two bits per cycle
    localparam int DIV_N_W     = WIN_W + 1;
    localparam int DIV_PAD_W   = DIV_N_W + (DIV_N_W % 2);
    localparam int DIV_STEPS   = DIV_PAD_W / 2;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_TAKE,
        OP_CHECK,
        OP_START_ACC,
        OP_UPDATE,
        OP_CLEAR,
        OP_LOAD_OUT
    } dp_op_t;

    typedef struct packed {
        logic   capture;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             dt_zero;
        logic             metered;
        logic             full;
        logic             div_busy;
    } dp_status_t;

endpackage

[design/mbtm_req_if.sv]
// ----------------------------------------------------------------------------
// mbtm_req_if: request channel
// Valid/ready channel carrying one meter request item.
// ----------------------------------------------------------------------------
interface mbtm_req_if
    import mbtm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [SRC_W-1:0] source_id;
    logic [CAP_W-1:0] amount;
    logic [WIN_W-1:0] elapsed_s;
    logic             fill_full;

    modport source (
        output valid, req_type, source_id, amount, elapsed_s, fill_full,
        input  ready
    );

    modport sink (
        input  valid, req_type, source_id, amount, elapsed_s, fill_full,
        output ready
    );
endinterface

[design/mbtm_rsp_if.sv]
// ----------------------------------------------------------------------------
// mbtm_rsp_if: result channel
// Valid/ready channel carrying the grant and the bucket levels.
// ----------------------------------------------------------------------------
interface mbtm_rsp_if
    import mbtm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] granted;
    logic [CAP_W-1:0] left_b0;
    logic [CAP_W-1:0] left_b1;
    logic [CAP_W-1:0] left_b2;
    logic [CAP_W-1:0] left_b3;

    modport source (
        output valid, granted, left_b0, left_b1, left_b2, left_b3,
        input  ready
    );

    modport sink (
        input  valid, granted, left_b0, left_b1, left_b2, left_b3,
        output ready
    );
endinterface

[design/mbtm_div.sv]
// ----------------------------------------------------------------------------
// mbtm_div: iterative unsigned divider
// Restoring division of a 33-bit dividend by a 32-bit divisor, two bits/cycle.
// ----------------------------------------------------------------------------
module mbtm_div
    import mbtm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [WIN_W-1:0]   divisor,
    output logic               busy,
    output logic [DIV_N_W-1:0] quotient,
    output logic [WIN_W-1:0]   remainder
);

    logic [DIV_PAD_W-1:0] work_reg, work_next;
    logic [WIN_W-1:0]     rem_reg, rem_next;
    logic [WIN_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic [WIN_W:0]       s1, s2;

    // one restoring step: {quotient bit, new partial remainder}
    function automatic logic [WIN_W:0] div_step(input logic [WIN_W-1:0] r,
                                                input logic             b,
                                                input logic [WIN_W-1:0] d);
        logic [WIN_W:0] t;
        logic [WIN_W:0] diff;
        t    = {r, b};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
            return {1'b1, diff[WIN_W-1:0]};
        else
            return {1'b0, t[WIN_W-1:0]};
    endfunction

    always_comb
    begin
        s1        = div_step(rem_reg, work_reg[DIV_PAD_W-1], dsr_reg);
        s2        = div_step(s1[WIN_W-1:0], work_reg[DIV_PAD_W-2], dsr_reg);
        work_next = {work_reg[DIV_PAD_W-3:0], s1[WIN_W], s2[WIN_W]};
        rem_next  = s2[WIN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= DIV_PAD_W'(dividend);
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = work_reg[DIV_N_W-1:0];
    assign remainder = rem_reg;

endmodule

[design/mbtm_dp.sv]
// ----------------------------------------------------------------------------
// mbtm_dp: token meter datapath
// Bucket state, configuration registers, shared divider and result register.
// ----------------------------------------------------------------------------
module mbtm_dp
    import mbtm_pkg::*;
#(
    parameter int BUCKETS = DEFAULT_BUCKETS,
    parameter int IDX_W   = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [SRC_W-1:0]      source,
    input  logic [CAP_W-1:0]      amount,
    input  logic [WIN_W-1:0]      elapsed_s,
    input  logic                  fill_full,
    input  dp_cmd_t               cmd,
    input  logic [IDX_W-1:0]      idx,
    output dp_status_t            status,
    output logic [CAP_W-1:0]      granted,
    output logic [CAP_W-1:0]      left_b0,
    output logic [CAP_W-1:0]      left_b1,
    output logic [CAP_W-1:0]      left_b2,
    output logic [CAP_W-1:0]      left_b3
);

    logic [REQ_W-1:0] req_reg;
    logic [SRC_W-1:0] src_reg;
    logic [CAP_W-1:0] amount_reg;
    logic [WIN_W-1:0] dt_reg;
    logic             fill_reg;
    logic [CAP_W-1:0] granted_reg;

    logic [CAP_W-1:0] cap_reg  [BUCKETS];
    logic [WIN_W-1:0] win_reg  [BUCKETS];
    logic [CAP_W-1:0] left_reg [BUCKETS];
    logic [WIN_W-1:0] rem_reg  [BUCKETS];

    logic [CAP_W-1:0] out_granted_reg;
    logic [CAP_W-1:0] out_left_reg [MAX_BUCKETS];

    logic [IDX_W-1:0]   rd_idx;
    logic               in_range;
    logic [CAP_W-1:0]   cap_sel, left_sel, grant, room;
    logic [WIN_W-1:0]   win_sel, rem_sel, dt_clamp;
    logic [DIV_N_W-1:0] acc;
    logic               metered, full;
    logic               div_start, div_busy;
    logic [DIV_N_W-1:0] div_dividend, div_quot;
    logic [WIN_W-1:0]   div_divisor, div_rem;
    logic               sat;
    logic [CAP_W-1:0]   left_next;
    logic [WIN_W-1:0]   rem_next;

    // a take addresses its own source, every other op the sweep index
    assign rd_idx   = (cmd.op == OP_TAKE) ? src_reg[IDX_W-1:0] : idx;
    assign in_range = (cmd.op == OP_TAKE) ? (int'(src_reg) < BUCKETS) : 1'b1;

    assign cap_sel  = cap_reg[rd_idx];
    assign win_sel  = win_reg[rd_idx];
    assign left_sel = left_reg[rd_idx];
    assign rem_sel  = rem_reg[rd_idx];

    // step of window / capacity is nonzero exactly when window >= capacity
    assign metered  = in_range && (cap_sel != '0) && (win_sel != '0)
                      && (win_sel >= WIN_W'(cap_sel));
    assign full     = left_sel >= cap_sel;
    assign dt_clamp = (dt_reg > win_sel) ? win_sel : dt_reg;
    assign acc      = DIV_N_W'(rem_sel) + DIV_N_W'(dt_clamp);
    assign room     = cap_sel - left_sel;
    assign grant    = (amount_reg > left_sel) ? left_sel : amount_reg;

    // first divide gives the step, second divides the carried remainder plus the clamped elapsed seconds by it
    assign div_start    = ((cmd.op == OP_CHECK) && metered && !full)
                          || (cmd.op == OP_START_ACC);
    assign div_dividend = (cmd.op == OP_START_ACC) ? acc : DIV_N_W'(win_sel);
    assign div_divisor  = (cmd.op == OP_START_ACC) ? div_quot[WIN_W-1:0]
                                                   : WIN_W'(cap_sel);

    mbtm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // refill result, saturating at capacity
    assign sat = div_quot >= DIV_N_W'(room);

    always_comb
    begin
        left_next = left_sel;
        rem_next  = rem_sel;
        case (cmd.op)
            OP_TAKE:
            begin
                if (metered)
                    left_next = left_sel - grant;
            end
            OP_CHECK:
            begin
                if (metered && full)
                begin
                    left_next = cap_sel;
                    rem_next  = '0;
                end
            end
            OP_UPDATE:
            begin
                if (sat)
                begin
                    left_next = cap_sel;
                    rem_next  = '0;
                end
                else
                begin
                    left_next = left_sel + div_quot[CAP_W-1:0];
                    rem_next  = div_rem;
                end
            end
            OP_CLEAR:
            begin
                left_next = (fill_reg && metered) ? cap_sel : '0;
                rem_next  = '0;
            end
            default:
            begin
                left_next = left_sel;
                rem_next  = rem_sel;
            end
        endcase
    end

    // item capture and grant
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg     <= req_type;
            src_reg     <= source;
            amount_reg  <= amount;
            dt_reg      <= elapsed_s;
            fill_reg    <= fill_full;
            granted_reg <= '0;
        end
        else if (cmd.op == OP_TAKE)
        begin
            granted_reg <= metered ? grant : amount_reg;
        end
    end

    // configuration and bucket state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < BUCKETS; b++)
            begin
                cap_reg[b]  <= '0;
                win_reg[b]  <= '0;
                left_reg[b] <= '0;
                rem_reg[b]  <= '0;
            end
        end
        else
        begin
            for (int b = 0; b < BUCKETS; b++)
            begin
                if (cfg_we && (cfg_index == CFG_IDX_W'(CFG_CAP_BASE + b)))
                    cap_reg[b] <= cfg_data[CAP_W-1:0];
                if (cfg_we && (cfg_index == CFG_IDX_W'(CFG_WIN_BASE + b)))
                    win_reg[b] <= cfg_data[WIN_W-1:0];
            end
            if (cmd.op == OP_TAKE || cmd.op == OP_CHECK ||
                cmd.op == OP_UPDATE || cmd.op == OP_CLEAR)
            begin
                if (in_range)
                begin
                    left_reg[rd_idx] <= left_next;
                    rem_reg[rd_idx]  <= rem_next;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD_OUT)
        begin
            out_granted_reg <= granted_reg;
            for (int b = 0; b < MAX_BUCKETS; b++)
            begin
                if (b < BUCKETS)
                    out_left_reg[b] <= left_reg[b];
                else
                    out_left_reg[b] <= '0;
            end
        end
    end

    assign granted = out_granted_reg;
    assign left_b0 = out_left_reg[0];
    assign left_b1 = out_left_reg[1];
    assign left_b2 = out_left_reg[2];
    assign left_b3 = out_left_reg[3];

    always_comb
    begin
        status.req      = req_reg;
        status.dt_zero  = (dt_reg == '0);
        status.metered  = metered;
        status.full     = full;
        status.div_busy = div_busy;
    end

endmodule

[design/mbtm_ctrl.sv]
// ----------------------------------------------------------------------------
// mbtm_ctrl: token meter controller
// Sequences take, tick and reset over the buckets and hands off the result.
// ----------------------------------------------------------------------------
module mbtm_ctrl
    import mbtm_pkg::*;
#(
    parameter int BUCKETS = DEFAULT_BUCKETS,
    parameter int IDX_W   = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output dp_cmd_t          cmd,
    output logic [IDX_W-1:0] idx,
    input  dp_status_t       status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_TAKE,
        S_CHECK,
        S_WAIT_STEP,
        S_WAIT_ACC,
        S_NEXT,
        S_CLEAR,
        S_OUT
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    logic             last;
    logic             load;

    assign last = (idx_reg == IDX_W'(BUCKETS - 1));
    assign load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        cmd.capture = in_valid && (state_reg == S_IDLE);
        unique case (state_reg)
            S_TAKE:      cmd.op = OP_TAKE;
            S_CHECK:     cmd.op = OP_CHECK;
            S_WAIT_STEP: cmd.op = status.div_busy ? OP_IDLE : OP_START_ACC;
            S_WAIT_ACC:  cmd.op = status.div_busy ? OP_IDLE : OP_UPDATE;
            S_CLEAR:     cmd.op = OP_CLEAR;
            S_OUT:       cmd.op = load ? OP_LOAD_OUT : OP_IDLE;
            default:     cmd.op = OP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_DISPATCH;
                end
                S_DISPATCH:
                begin
                    idx_reg <= '0;
                    unique case (status.req)
                        REQ_TAKE:  state_reg <= S_TAKE;
                        REQ_TICK:  state_reg <= status.dt_zero ? S_OUT : S_CHECK;
                        REQ_RESET: state_reg <= S_CLEAR;
                        default:   state_reg <= S_OUT;
                    endcase
                end
                S_TAKE:
                begin
                    state_reg <= S_OUT;
                end
                S_CHECK:
                begin
                    if (status.metered && !status.full)
                        state_reg <= S_WAIT_STEP;
                    else
                        state_reg <= S_NEXT;
                end
                S_WAIT_STEP:
                begin
                    if (!status.div_busy)
                        state_reg <= S_WAIT_ACC;
                end
                S_WAIT_ACC:
                begin
                    if (!status.div_busy)
                        state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (last)
                        state_reg <= S_OUT;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_CHECK;
                    end
                end
                S_CLEAR:
                begin
                    if (last)
                        state_reg <= S_OUT;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_OUT:
                begin
                    if (load)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign idx       = idx_reg;

endmodule

[design/multi_bucket_token_meter.sv]
// sequence: take updates its source bucket, reset clears each bucket in turn,
//   an ignored request or a tick with zero elapsed time goes straight to output,
//   other ticks check each bucket and run two 17-step divides per refilling one
// throughput: one item at a time; a new item is taken once the previous
//   result sits in the output register, even while it is still unread
// reset: asynchronous active-low rst_n clears buckets, remainders and config
// ----------------------------------------------------------------------------
// multi_bucket_token_meter: four-bucket token meter
// Per-bucket token buckets with capacity and refill window; take, tick and
// reset requests, one result item per request item.
// ----------------------------------------------------------------------------
module multi_bucket_token_meter
    import mbtm_pkg::*;
#(
    parameter int BUCKETS = DEFAULT_BUCKETS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mbtm_req_if.sink              request,
    mbtm_rsp_if.source            result
);

    // bucket index width, at least one bit
    localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [IDX_W-1:0] idx;

    // controller: request decode, bucket sweep, divider waits, output handoff
    mbtm_ctrl #(
        .BUCKETS (BUCKETS),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .idx       (idx),
        .status    (status)
    );

    // datapath: config, bucket levels and remainders, divider, result register
    mbtm_dp #(
        .BUCKETS (BUCKETS),
        .IDX_W   (IDX_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_type  (request.req_type),
        .source    (request.source_id),
        .amount    (request.amount),
        .elapsed_s (request.elapsed_s),
        .fill_full (request.fill_full),
        .cmd       (cmd),
        .idx       (idx),
        .status    (status),
        .granted   (result.granted),
        .left_b0   (result.left_b0),
        .left_b1   (result.left_b1),
        .left_b2   (result.left_b2),
        .left_b3   (result.left_b3)
    );

endmodule

[design/mbtm_checker.sv]
// ----------------------------------------------------------------------------
// mbtm_checker: port-level checks of the token meter
// Result handshake and one-item-at-a-time sequencing seen at the ports.
// ----------------------------------------------------------------------------
module mbtm_checker
    import mbtm_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [CAP_W-1:0] granted,
    input logic [CAP_W-1:0] left_b0,
    input logic [CAP_W-1:0] left_b1,
    input logic [CAP_W-1:0] left_b2,
    input logic [CAP_W-1:0] left_b3
);

    // a result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped before it was taken");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(granted) && $stable(left_b0)
            && $stable(left_b1) && $stable(left_b2) && $stable(left_b3))
        else $error("result payload changed while stalled");

    // an accepted item keeps the meter busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted right after another one");

    // a new result only comes out of an item in flight
    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while no item was in flight");

endmodule

bind multi_bucket_token_meter mbtm_checker u_mbtm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .granted   (result.granted),
    .left_b0   (result.left_b0),
    .left_b1   (result.left_b1),
    .left_b2   (result.left_b2),
    .left_b3   (result.left_b3)
);

[tb/sv/multi_bucket_token_meter_test.sv]
// ----------------------------------------------------------------------------
// multi_bucket_token_meter_test: self-checking bench for the token meter
// Drives take, tick and reset request items through the request channel,
// predicts the grant and every bucket level in a local copy of the meter,
// and compares each result item as it leaves the block. Register settings
// change between phases while the block is idle, and both channels stall.
// ----------------------------------------------------------------------------
module multi_bucket_token_meter_test;
    import mbtm_pkg::*;

    // opcode the block must ignore, still answered with one result item
    localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;

    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 105;
    localparam int PRESSURE_ITEMS   = 30;
    localparam int PRESSURE_HOLD    = 400;
    // the longest result latency is that of a full tick
    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_CYCLES     = 200;
    localparam int RUN_LIMIT        = 4_000_000;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [SRC_W-1:0] source;
        logic [CAP_W-1:0] amount;
        logic [WIN_W-1:0] elapsed_s;
        logic             fill_full;
    } meter_req_t;

    typedef struct packed {
        logic [CAP_W-1:0]                   granted;
        logic [MAX_BUCKETS-1:0][CAP_W-1:0]  left;
    } meter_rsp_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mbtm_req_if req_ch ();
    mbtm_rsp_if rsp_ch ();

    multi_bucket_token_meter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .request   (req_ch),
        .result    (rsp_ch)
    );

    // local copy of the meter: register settings and bucket state
    logic [CAP_W-1:0] cap_setting    [MAX_BUCKETS];
    logic [WIN_W-1:0] window_setting [MAX_BUCKETS];
    logic [CAP_W-1:0] bucket_tokens  [MAX_BUCKETS];
    logic [WIN_W-1:0] carry_s        [MAX_BUCKETS];

    // grants and levels still owed by the block, oldest first
    meter_rsp_t expected_levels [$];

    int  error_count     = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  settings_loaded = 0;
    int  type_count [4]  = '{0, 0, 0, 0};
    // steady_flow turns off idling on both sides; hold_off_cycles asks the
    // receiver for one long stall
    bit  steady_flow     = 1'b0;
    int  hold_off_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // seconds per token; zero means the bucket is not metered
    function automatic logic [WIN_W-1:0] seconds_per_token(input int b);
        if (b >= DEFAULT_BUCKETS)
            return '0;
        if (cap_setting[b] == '0 || window_setting[b] == '0)
            return '0;
        return window_setting[b] / WIN_W'(cap_setting[b]);
    endfunction

    function automatic void refill_bucket(input int b, input logic [WIN_W-1:0] dt);
        logic [WIN_W-1:0] step;
        logic [WIN_W-1:0] span;
        logic [63:0]      acc;
        logic [63:0]      level;
        step = seconds_per_token(b);
        if (step == '0)
            return;
        // at or above capacity: pin to capacity, drop partial seconds
        if (bucket_tokens[b] >= cap_setting[b])
        begin
            bucket_tokens[b] = cap_setting[b];
            carry_s[b]       = '0;
            return;
        end
        // no more than one window's worth of seconds counts
        span  = (dt > window_setting[b]) ? window_setting[b] : dt;
        acc   = 64'(carry_s[b]) + 64'(span);
        carry_s[b] = WIN_W'(acc % 64'(step));
        level = 64'(bucket_tokens[b]) + acc / 64'(step);
        if (level >= 64'(cap_setting[b]))
        begin
            level      = 64'(cap_setting[b]);
            carry_s[b] = '0;
        end
        bucket_tokens[b] = CAP_W'(level);
    endfunction

    // advances the local meter by one accepted item, returns its result
    function automatic meter_rsp_t predict_meter_result(input meter_req_t r);
        meter_rsp_t  e;
        logic [WIN_W-1:0] step;
        int          s;
        e.granted = '0;
        s = int'(r.source);
        case (r.req_type)
            REQ_TAKE:
            begin
                step = seconds_per_token(s);
                if (step == '0)
                    e.granted = r.amount;   // unmetered source passes through
                else
                begin
                    e.granted = (r.amount > bucket_tokens[s]) ? bucket_tokens[s]
                                                              : r.amount;
                    bucket_tokens[s] = bucket_tokens[s] - e.granted;
                end
            end
            REQ_TICK:
            begin
                if (r.elapsed_s != '0)
                    for (int b = 0; b < MAX_BUCKETS; b++)
                        refill_bucket(b, r.elapsed_s);
            end
            REQ_RESET:
            begin
                for (int b = 0; b < MAX_BUCKETS; b++)
                begin
                    bucket_tokens[b] = (r.fill_full && seconds_per_token(b) != '0)
                                       ? cap_setting[b] : '0;
                    carry_s[b] = '0;
                end
            end
            default: ;
        endcase
        for (int b = 0; b < MAX_BUCKETS; b++)
            e.left[b] = (b < DEFAULT_BUCKETS) ? bucket_tokens[b] : '0;
        return e;
    endfunction

    function automatic meter_req_t make_request(input logic [REQ_W-1:0] kind,
                                                input logic [SRC_W-1:0] src,
                                                input logic [CAP_W-1:0] amt,
                                                input logic [WIN_W-1:0] dt,
                                                input logic             fill);
        meter_req_t r;
        r.req_type  = kind;
        r.source    = src;
        r.amount    = amt;
        r.elapsed_s = dt;
        r.fill_full = fill;
        return r;
    endfunction

    // mostly short pauses, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    function automatic int sender_gap();
        if (steady_flow || $urandom_range(0, 1) == 0)
            return 0;
        return idle_length();
    endfunction

    // random item shaped around the current settings, so that grants,
    // refills and saturation all happen; unused fields carry noise
    function automatic meter_req_t random_request();
        meter_req_t r;
        int         pick;
        int         sel;
        int         b;
        logic [WIN_W-1:0] step;
        logic [63:0]      scale;
        r.source    = SRC_W'($urandom);
        r.amount    = CAP_W'($urandom);
        r.elapsed_s = $urandom;
        r.fill_full = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            r.req_type = REQ_TAKE;
            r.source   = ($urandom_range(0, 6) == 0) ? SRC_W'($urandom_range(4, 7))
                                                     : SRC_W'($urandom_range(0, 3));
            sel = $urandom_range(0, 9);
            if (sel < 6)
                r.amount = CAP_W'($urandom_range(0, int'(cap_setting[r.source[1:0]]) + 2));
            else if (sel < 8)
                r.amount = CAP_W'($urandom_range(0, 3));
        end
        else if (pick < 90)
        begin
            r.req_type = REQ_TICK;
            b     = $urandom_range(0, 3);
            step  = seconds_per_token(b);
            scale = (step == '0) ? 64'd1000 : 64'(step) * 3;
            if (scale > 64'hFFFF_FFFF)
                scale = 64'hFFFF_FFFF;
            sel = $urandom_range(0, 99);
            if (sel < 8)
                r.elapsed_s = '0;
            else if (sel >= 18)
                r.elapsed_s = $urandom_range(0, 32'(scale));
        end
        else if (pick < 97)
            r.req_type = REQ_RESET;
        else
            r.req_type = REQ_IGNORED;
        return r;
    endfunction

    // offers one item, waits for the handshake, then books its result;
    // valid stays high when the next item follows without a gap
    task automatic send_request(input meter_req_t item);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= item.req_type;
        req_ch.source_id <= item.source;
        req_ch.amount    <= item.amount;
        req_ch.elapsed_s <= item.elapsed_s;
        req_ch.fill_full <= item.fill_full;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        expected_levels.push_back(predict_meter_result(item));
        items_sent++;
        type_count[item.req_type]++;
    endtask

    // every item answers, so an empty queue means the block has gone idle;
    // the last item is no longer offered while waiting
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves cfg_we high so back-to-back writes need one assignment a cycle
    task automatic write_register(input int index, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(index);
        cfg_data  <= data;
        @(posedge clk);
        if (index < CFG_WIN_BASE)
            cap_setting[index - CFG_CAP_BASE] = data[CAP_W-1:0];
        else
            window_setting[index - CFG_WIN_BASE] = data;
    endtask

    task automatic program_registers(input logic [MAX_BUCKETS-1:0][CAP_W-1:0] caps,
                                     input logic [MAX_BUCKETS-1:0][WIN_W-1:0] wins);
        wait_idle();
        // upper data bits of a capacity write are junk and must be dropped
        for (int b = 0; b < MAX_BUCKETS; b++)
            write_register(CFG_CAP_BASE + b, {16'($urandom), caps[b]});
        for (int b = 0; b < MAX_BUCKETS; b++)
            write_register(CFG_WIN_BASE + b, wins[b]);
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // ------------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------------

    // all registers at zero after reset: every source passes through
    task automatic test_unmetered_after_reset();
        send_request(make_request(REQ_TAKE, 3'd0, 16'hFFFF, '0, 1'b0));
        send_request(make_request(REQ_TICK, 3'd1, 16'h0000, 32'hFFFF_FFFF, 1'b1));
        send_request(make_request(REQ_IGNORED, SRC_W'($urandom), CAP_W'($urandom),
                                  $urandom, 1'($urandom)));
        send_request(make_request(REQ_TAKE, 3'd6, 16'h1234, '0, 1'b0));
    endtask

    task automatic test_directed_cases();
        logic [MAX_BUCKETS-1:0][CAP_W-1:0] caps;
        logic [MAX_BUCKETS-1:0][WIN_W-1:0] wins;
        // bucket 0 ten seconds a token, bucket 1 window below capacity,
        // bucket 2 at the largest settings, bucket 3 the smallest metered one
        caps[0] = 16'd10;     wins[0] = 32'd100;
        caps[1] = 16'd5;      wins[1] = 32'd3;
        caps[2] = 16'hFFFF;   wins[2] = 32'hFFFF_FFFF;
        caps[3] = 16'd1;      wins[3] = 32'd1;
        program_registers(caps, wins);

        send_request(make_request(REQ_RESET, 3'd0, '0, '0, 1'b1));
        send_request(make_request(REQ_TAKE, 3'd0, 16'd0, '0, 1'b0));
        send_request(make_request(REQ_TAKE, 3'd0, 16'd4, '0, 1'b0));
        // asks more than is left: grant is what remains
        send_request(make_request(REQ_TAKE, 3'd0, 16'hFFFF, '0, 1'b0));
        send_request(make_request(REQ_TAKE, 3'd1, 16'd7, '0, 1'b0));
        send_request(make_request(REQ_TAKE, 3'd5, 16'hAAAA, '0, 1'b0));
        send_request(make_request(REQ_TAKE, 3'd7, 16'h5555, '0, 1'b1));
        send_request(make_request(REQ_TICK, 3'd0, '0, 32'd0, 1'b0));
        // partial refill leaves a seconds remainder in bucket 0
        send_request(make_request(REQ_TICK, 3'd0, '0, 32'd25, 1'b0));
        // clamped to one window, refills up to capacity
        send_request(make_request(REQ_TICK, 3'd0, '0, 32'hFFFF_FFFF, 1'b0));
        send_request(make_request(REQ_TAKE, 3'd3, 16'd1, '0, 1'b0));
        send_request(make_request(REQ_TAKE, 3'd2, 16'hFFFF, '0, 1'b0));
        send_request(make_request(REQ_TICK, 3'd0, '0, 32'd196_616, 1'b0));
        send_request(make_request(REQ_RESET, 3'd0, '0, '0, 1'b0));
        send_request(make_request(REQ_IGNORED, 3'd2, 16'd9, 32'd9, 1'b1));
        send_request(make_request(REQ_RESET, 3'd0, '0, '0, 1'b1));

        // lower capacity while bucket 0 is full: it now holds above capacity
        wait_idle();
        write_register(CFG_CAP_BASE + 0, 32'd4);
        cfg_we <= 1'b0;
        settings_loaded++;
        send_request(make_request(REQ_TAKE, 3'd0, 16'd3, '0, 1'b0));
        send_request(make_request(REQ_TICK, 3'd0, '0, 32'd1, 1'b0));

        // capacity with a zero window is unmetered, emptied by a fill
        wait_idle();
        write_register(CFG_WIN_BASE + 1, 32'd0);
        cfg_we <= 1'b0;
        settings_loaded++;
        send_request(make_request(REQ_RESET, 3'd0, '0, '0, 1'b1));
        send_request(make_request(REQ_TAKE, 3'd1, 16'd2, '0, 1'b0));
    endtask

    task automatic test_random_traffic();
        logic [MAX_BUCKETS-1:0][CAP_W-1:0] caps;
        logic [MAX_BUCKETS-1:0][WIN_W-1:0] wins;
        int mode;
        int step;
        int start;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            for (int b = 0; b < MAX_BUCKETS; b++)
            begin
                mode = $urandom_range(0, 9);
                case (mode)
                    0:
                    begin
                        caps[b] = '0;
                        wins[b] = $urandom;
                    end
                    1:
                    begin
                        caps[b] = CAP_W'($urandom_range(1, 65535));
                        wins[b] = '0;
                    end
                    2:
                    begin
                        caps[b] = CAP_W'($urandom_range(2, 1000));
                        wins[b] = $urandom_range(1, int'(caps[b]) - 1);
                    end
                    3:
                    begin
                        caps[b] = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'd1;
                        wins[b] = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'd1;
                    end
                    default:
                    begin
                        // ordinary bucket: a few dozen tokens, odd window
                        caps[b] = CAP_W'($urandom_range(1, 64));
                        step    = $urandom_range(1, 400);
                        wins[b] = WIN_W'(int'(caps[b]) * step + $urandom_range(0, step - 1));
                    end
                endcase
            end
            program_registers(caps, wins);
            // every fourth phase runs with no idling on either side
            steady_flow = (phase % 4 == 3);
            // usually start from full buckets; sometimes keep old levels,
            // which may sit above a freshly lowered capacity
            start = $urandom_range(0, 9);
            if (start < 7)
                send_request(make_request(REQ_RESET, SRC_W'($urandom), CAP_W'($urandom),
                                          $urandom, 1'b1));
            else if (start < 8)
                send_request(make_request(REQ_RESET, SRC_W'($urandom), CAP_W'($urandom),
                                          $urandom, 1'b0));
            repeat (ITEMS_PER_PHASE) send_request(random_request());
        end
        steady_flow = 1'b0;
    endtask

    // receiver holds off for a long stretch while items keep coming, so the
    // output register fills and the request channel has to stall
    task automatic test_backpressure();
        wait_idle();
        steady_flow     = 1'b1;
        hold_off_cycles = PRESSURE_HOLD;
        repeat (PRESSURE_ITEMS) send_request(random_request());
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result side: ready pattern and checking
    // ------------------------------------------------------------------------

    initial
    begin : result_ready
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            else if (!steady_flow && $urandom_range(0, 2) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (idle_length()) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // compare each accepted result item with the oldest prediction
    always @(posedge clk)
    begin : result_check
        meter_rsp_t                        want;
        logic [MAX_BUCKETS-1:0][CAP_W-1:0] seen;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen = {rsp_ch.left_b3, rsp_ch.left_b2, rsp_ch.left_b1, rsp_ch.left_b0};
            results_checked++;
            if (expected_levels.size() == 0)
            begin
                $error("result item with no request outstanding: granted %0d",
                       rsp_ch.granted);
                error_count++;
            end
            else
            begin
                want = expected_levels.pop_front();
                if (rsp_ch.granted !== want.granted)
                begin
                    $error("granted expected %0d actual %0d", want.granted,
                           rsp_ch.granted);
                    error_count++;
                end
                for (int b = 0; b < MAX_BUCKETS; b++)
                begin
                    if (seen[b] !== want.left[b])
                    begin
                        $error("left_b%0d expected %0d actual %0d", b, want.left[b],
                               seen[b]);
                        error_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_TAKE;
        req_ch.source_id = '0;
        req_ch.amount    = '0;
        req_ch.elapsed_s = '0;
        req_ch.fill_full = 1'b0;
        // local copy matches the block's reset state
        for (int b = 0; b < MAX_BUCKETS; b++)
        begin
            cap_setting[b]    = '0;
            window_setting[b] = '0;
            bucket_tokens[b]  = '0;
            carry_s[b]        = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unmetered_after_reset();
        test_directed_cases();
        test_random_traffic();
        test_backpressure();

        req_ch.valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge clk);
        // catch any stray result item after the last one expected
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d request items (%0d take, %0d tick, %0d reset, %0d ignored)",
                 items_sent, type_count[0], type_count[1], type_count[2], type_count[3]);
        $display("checked %0d result items across %0d register settings",
                 results_checked, settings_loaded);
        if (error_count == 0)
            $display("multi_bucket_token_meter_test: clean");
        else
            $display("multi_bucket_token_meter_test: errors");
        $finish;
    end

    // watchdog well above the slowest legal run
    initial
    begin
        #RUN_LIMIT;
        $display("multi_bucket_token_meter_test: errors");
        $finish;
    end

endmodule

[sim.f]
design/mbtm_pkg.sv
design/mbtm_req_if.sv
design/mbtm_rsp_if.sv
design/mbtm_div.sv
design/mbtm_dp.sv
design/mbtm_ctrl.sv
design/multi_bucket_token_meter.sv
design/mbtm_checker.sv
tb/sv/multi_bucket_token_meter_test.sv
